// File: rtl/core/skt_pkg.sv
`default_nettype none

package skt_pkg;

   localparam int KEY_W     = 64;
   localparam int MOVE_W    = 16;
   localparam int WEIGHT_W  = 16;
   localparam int LEARN_W   = 32;
   localparam int PAYLOAD_W = MOVE_W + WEIGHT_W + LEARN_W;
   localparam int INDEX_W   = 14;
   localparam int COUNT_W   = 15;

   localparam int DEF_TABLE_DEPTH = 16384;
   localparam int DEF_MAX_MATCHES = 64;

   // command queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // classified work item: keys and payloads already in numeric byte order
   typedef struct packed {
      logic                 is_probe;
      logic [INDEX_W-1:0]   addr;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/skt_req_if.sv
`default_nettype none

interface skt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [skt_pkg::INDEX_W-1:0]  load_index;
   logic [skt_pkg::KEY_W-1:0]    raw_key;
   logic [skt_pkg::MOVE_W-1:0]   raw_move;
   logic [skt_pkg::WEIGHT_W-1:0] raw_weight;
   logic [skt_pkg::LEARN_W-1:0]  raw_learn;
   logic [skt_pkg::KEY_W-1:0]    probe_key;

   modport source (
      output valid, mode, load_index, raw_key, raw_move, raw_weight, raw_learn, probe_key,
      input  ready
   );

   modport sink (
      input  valid, mode, load_index, raw_key, raw_move, raw_weight, raw_learn, probe_key,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/skt_rsp_if.sv
`default_nettype none

interface skt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [skt_pkg::INDEX_W-1:0]  entry_index;
   logic [skt_pkg::MOVE_W-1:0]   move_word;
   logic [skt_pkg::WEIGHT_W-1:0] weight_word;
   logic [skt_pkg::LEARN_W-1:0]  learn_word;
   logic                         last;
   logic                         more_remaining;

   modport source (
      output valid, found, entry_index, move_word, weight_word, learn_word, last,
             more_remaining,
      input  ready
   );

   modport sink (
      input  valid, found, entry_index, move_word, weight_word, learn_word, last,
             more_remaining,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/skt_csr_if.sv
`default_nettype none

interface skt_csr_if;
   logic                        valid;
   logic                        ready;
   logic [skt_pkg::COUNT_W-1:0] entry_count;

   modport source (
      output valid, entry_count,
      input  ready
   );

   modport sink (
      input  valid, entry_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/skt_queue.sv
`default_nettype none

module skt_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire skt_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output skt_pkg::cmd_type      pop_data
);

   localparam int PW = (skt_pkg::QUEUE_DEPTH > 1) ? $clog2(skt_pkg::QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(skt_pkg::QUEUE_DEPTH + 1);

   skt_pkg::cmd_type entries_ff [skt_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == FW'(skt_pkg::QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(skt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(skt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/skt_front.sv
`default_nettype none

module skt_front #(
   parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH
) (
   skt_req_if.sink             req,
   output logic                push,
   output skt_pkg::cmd_type    push_data,
   input  wire logic           full
);

   localparam logic MODE_PROBE = 1'b1;
   localparam int   RW = (skt_pkg::INDEX_W + 1 > $clog2(TABLE_DEPTH + 1)) ?
                         skt_pkg::INDEX_W + 1 : $clog2(TABLE_DEPTH + 1);

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {swap16(v[15:0]), swap16(v[31:16])};
   endfunction

   function automatic logic [63:0] swap64(input logic [63:0] v);
      return {swap32(v[31:0]), swap32(v[63:32])};
   endfunction

   logic accept, is_probe, in_range;

   assign req.ready = !full;
   assign accept    = req.valid && !full;
   assign is_probe  = (req.mode == MODE_PROBE);
   assign in_range  = (RW'(req.load_index) < RW'(TABLE_DEPTH));

   // loads past the end of the table are dropped here
   assign push = accept && (is_probe || in_range);

   always_comb begin
      push_data.is_probe = is_probe;
      push_data.addr     = req.load_index;
      push_data.key      = is_probe ? req.probe_key : swap64(req.raw_key);
      push_data.payload  = {swap16(req.raw_move), swap16(req.raw_weight),
                            swap32(req.raw_learn)};
   end

endmodule

`default_nettype wire

// File: rtl/core/skt_engine.sv
`default_nettype none

module skt_engine #(
   parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_MATCHES = skt_pkg::DEF_MAX_MATCHES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   skt_csr_if.sink               csr,
   skt_rsp_if.source             rsp,
   output logic                  pop,
   input  wire logic             empty,
   input  wire skt_pkg::cmd_type pop_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = (skt_pkg::COUNT_W > $clog2(TABLE_DEPTH + 1)) ?
                       skt_pkg::COUNT_W : $clog2(TABLE_DEPTH + 1);
   localparam int MW = $clog2(MAX_MATCHES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_SCAN,
      ST_CHECK,
      ST_END
   } state_type;

   // table storage
   logic [skt_pkg::KEY_W-1:0]     key_mem_ff [TABLE_DEPTH];
   logic [skt_pkg::PAYLOAD_W-1:0] pay_mem_ff [TABLE_DEPTH];
   logic [skt_pkg::KEY_W-1:0]     rkey_ff;
   logic [skt_pkg::PAYLOAD_W-1:0] rpay_ff;
   logic                          wr_en, rd_en;
   logic [AW-1:0]                 wr_addr, rd_addr;

   state_type                     state_ff, state_in;
   logic [skt_pkg::COUNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [skt_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [NW-1:0]                 lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [AW-1:0]                 mid_ff, mid_in;
   logic [MW-1:0]                 cnt_ff, cnt_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [skt_pkg::INDEX_W-1:0]   pend_index_ff, pend_index_in;
   logic [skt_pkg::PAYLOAD_W-1:0] pend_pay_ff, pend_pay_in;
   logic                          more_ff, more_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [skt_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [skt_pkg::PAYLOAD_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_more_ff, rsp_more_in;

   logic [NW-1:0]                 n_eff, mid_calc;
   logic                          out_free, emit, match;

   assign csr.ready = 1'b1;

   assign n_eff    = (NW'(entry_count_ff) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                               : NW'(entry_count_ff);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign match    = (rkey_ff == key_ff);
   assign wr_addr  = AW'(pop_data.addr);

   always_comb begin
      state_in       = state_ff;
      entry_count_in = (csr.valid) ? csr.entry_count : entry_count_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      mid_in         = mid_ff;
      cnt_in         = cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_index_in  = pend_index_ff;
      pend_pay_in    = pend_pay_ff;
      more_in        = more_ff;
      pop            = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = mid_calc[AW-1:0];
      emit           = 1'b0;
      rsp_found_in   = rsp_found_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_pay_in     = rsp_pay_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_more_in    = rsp_more_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (pop_data.is_probe) begin
                  key_in        = pop_data.key;
                  lo_in         = '0;
                  hi_in         = n_eff;
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SEARCH;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_calc[AW-1:0];
               mid_in   = mid_calc[AW-1:0];
               state_in = ST_COMPARE;
            end else begin
               idx_in   = lo_ff;
               state_in = ST_SCAN;
            end
         end
         ST_COMPARE: begin
            if (rkey_ff < key_ff) begin
               lo_in = NW'(mid_ff) + 1'b1;
            end else begin
               hi_in = NW'(mid_ff);
            end
            state_in = ST_SEARCH;
         end
         ST_SCAN: begin
            if (idx_ff < n_eff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = ST_CHECK;
            end else begin
               more_in  = 1'b0;
               state_in = ST_END;
            end
         end
         ST_CHECK: begin
            if (match && (cnt_ff < MW'(MAX_MATCHES))) begin
               // hold the new match; the previous one is known not to be last
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     emit         = 1'b1;
                     rsp_found_in = 1'b1;
                     rsp_index_in = pend_index_ff;
                     rsp_pay_in   = pend_pay_ff;
                     rsp_last_in  = 1'b0;
                     rsp_more_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_index_in = idx_ff[skt_pkg::INDEX_W-1:0];
                  pend_pay_in   = rpay_ff;
                  cnt_in        = cnt_ff + 1'b1;
                  idx_in        = idx_ff + 1'b1;
                  state_in      = ST_SCAN;
               end
            end else begin
               more_in  = match;
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_found_in = pend_valid_ff;
               rsp_index_in = pend_valid_ff ? pend_index_ff : '0;
               rsp_pay_in   = pend_valid_ff ? pend_pay_ff : '0;
               rsp_last_in  = 1'b1;
               rsp_more_in  = pend_valid_ff && more_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      mid_ff        <= mid_in;
      cnt_ff        <= cnt_in;
      pend_index_ff <= pend_index_in;
      pend_pay_ff   <= pend_pay_in;
      more_ff       <= more_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_more_ff   <= rsp_more_in;
   end

   // single-port table: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= pop_data.key;
         pay_mem_ff[wr_addr] <= pop_data.payload;
      end
      if (rd_en) begin
         rkey_ff <= key_mem_ff[rd_addr];
         rpay_ff <= pay_mem_ff[rd_addr];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.found          = rsp_found_ff;
   assign rsp.entry_index    = rsp_index_ff;
   assign rsp.move_word      = rsp_pay_ff[skt_pkg::PAYLOAD_W-1 -: skt_pkg::MOVE_W];
   assign rsp.weight_word    = rsp_pay_ff[skt_pkg::LEARN_W +: skt_pkg::WEIGHT_W];
   assign rsp.learn_word     = rsp_pay_ff[skt_pkg::LEARN_W-1:0];
   assign rsp.last           = rsp_last_ff;
   assign rsp.more_remaining = rsp_more_ff;

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_table_probe.sv
// Sorted key table probe: lower-bound search over a key-sorted entry table.
//
// Channels: req (items in), rsp (results out), csr (entry_count writes), all
// valid/ready; an item moves on a clock edge with valid and ready both high.
// A load item (mode 0) byte-swaps its big-endian words and writes one entry;
// it gives no result, and a load_index past the table end is dropped.
// A probe item (mode 1) binary-searches the first entry_count entries, then
// walks forward and returns each matching entry, last set on the final one.
// No match gives a single result with found clear. At most MAX_MATCHES results
// per probe; more_remaining marks a cut-off run.
// Flow: the queue between front and back end holds two items, so req drops
// ready only while both slots are full. The back end owns the single-port
// table: a load is one write there; a probe searches with a read, then a
// compare, per step, then reads and checks each entry it scans, then gives
// its last result. The table port sets the pace.
// Reset clears control state and entry_count; table contents stay undefined
// until loaded. A stalled rsp holds its result; the scan waits behind it.
`default_nettype none

module sorted_key_table_probe #(
   parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_MATCHES = skt_pkg::DEF_MAX_MATCHES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   skt_req_if.sink    req,
   skt_rsp_if.source  rsp,
   skt_csr_if.sink    csr
);

   skt_pkg::cmd_type push_data, pop_data;
   logic             push, full, pop, empty;

   // classify and byte-swap
   skt_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .req       (req),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // decouples intake from the search engine
   skt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (pop_data)
   );

   // table, search, scan and result register
   skt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_MATCHES (MAX_MATCHES)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .rsp      (rsp),
      .pop      (pop),
      .empty    (empty),
      .pop_data (pop_data)
   );

endmodule

`default_nettype wire

// File: dv/tb_sorted_key_table_probe.sv
`default_nettype none

module tb_sorted_key_table_probe;

   localparam int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH;
   localparam int MAX_MATCHES = skt_pkg::DEF_MAX_MATCHES;

   // item kinds on the req channel
   localparam bit MODE_LOAD  = 1'b0;
   localparam bit MODE_PROBE = 1'b1;

   // loads give no result, so after the last expected result the back end may
   // still be writing the table; this many cycles covers the queued work
   localparam int SETTLE_CYCLES = 64;

   localparam bit [skt_pkg::COUNT_W-1:0] COUNT_ALL_ONES = '1;

   // one req item as the testbench builds it
   typedef struct packed {
      logic                         mode;
      logic [skt_pkg::INDEX_W-1:0]  load_index;
      logic [skt_pkg::KEY_W-1:0]    raw_key;
      logic [skt_pkg::MOVE_W-1:0]   raw_move;
      logic [skt_pkg::WEIGHT_W-1:0] raw_weight;
      logic [skt_pkg::LEARN_W-1:0]  raw_learn;
      logic [skt_pkg::KEY_W-1:0]    probe_key;
   } table_req_t;

   // one rsp item: a matching entry or the single no-match answer
   typedef struct packed {
      logic                         found;
      logic [skt_pkg::INDEX_W-1:0]  entry_index;
      logic [skt_pkg::MOVE_W-1:0]   move_word;
      logic [skt_pkg::WEIGHT_W-1:0] weight_word;
      logic [skt_pkg::LEARN_W-1:0]  learn_word;
      logic                         last;
      logic                         more_remaining;
   } match_t;

   bit clock = 1'b0;
   bit reset = 1'b1;

   skt_req_if req_if ();
   skt_rsp_if rsp_if ();
   skt_csr_if csr_if ();

   sorted_key_table_probe #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_MATCHES (MAX_MATCHES)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the table and of entry_count, kept in numeric byte order
   bit [skt_pkg::KEY_W-1:0]     key_mem     [0:TABLE_DEPTH-1];
   bit [skt_pkg::PAYLOAD_W-1:0] payload_mem [0:TABLE_DEPTH-1];
   bit [skt_pkg::COUNT_W-1:0]   search_count = '0;

   match_t expected_q [$];
   int     error_count = 0;

   // pacing knobs: set per phase to get stretches with no idling at all
   bit send_quick    = 1'b0;
   bit recv_no_stall = 1'b0;
   bit recv_ready    = 1'b0;
   int recv_stall_left = 0;

   assign rsp_if.ready = recv_ready;

   // ---------------------------------------------------------------------
   // byte order helpers (book file words are big-endian)
   // ---------------------------------------------------------------------
   function automatic bit [15:0] swap_bytes16(bit [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic bit [31:0] swap_bytes32(bit [31:0] v);
      return {swap_bytes16(v[15:0]), swap_bytes16(v[31:16])};
   endfunction

   function automatic bit [63:0] swap_bytes64(bit [63:0] v);
      return {swap_bytes32(v[31:0]), swap_bytes32(v[63:32])};
   endfunction

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap(bit quick);
      int r;
      if (quick)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // predictor: applies a load, or runs the lower-bound search plus forward
   // scan on the shadow table and queues the results a probe must give
   // ---------------------------------------------------------------------
   task automatic predict_item(table_req_t it);
      int     n, lo, hi, mid, idx, cnt;
      bit     next_hit;
      match_t m;
      if (it.mode == MODE_LOAD) begin
         key_mem[it.load_index]     = swap_bytes64(it.raw_key);
         payload_mem[it.load_index] = {swap_bytes16(it.raw_move),
                                       swap_bytes16(it.raw_weight),
                                       swap_bytes32(it.raw_learn)};
      end else begin
         // counts past the table end saturate
         n  = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mem[mid] < it.probe_key)
               lo = mid + 1;
            else
               hi = mid;
         end
         idx = lo;
         cnt = 0;
         while (idx < n && key_mem[idx] == it.probe_key && cnt < MAX_MATCHES) begin
            next_hit = (idx + 1 < n) && (key_mem[idx + 1] == it.probe_key);
            m.found          = 1'b1;
            m.entry_index    = idx[skt_pkg::INDEX_W-1:0];
            m.move_word      = payload_mem[idx][63:48];
            m.weight_word    = payload_mem[idx][47:32];
            m.learn_word     = payload_mem[idx][31:0];
            // last on the final match, or where the result limit cuts the run
            m.last           = !next_hit || (cnt == MAX_MATCHES - 1);
            m.more_remaining = next_hit && (cnt == MAX_MATCHES - 1);
            expected_q.push_back(m);
            cnt++;
            idx++;
         end
         if (cnt == 0) begin
            // no match: one all-zero result with last set
            m      = '0;
            m.last = 1'b1;
            expected_q.push_back(m);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // req side
   // ---------------------------------------------------------------------
   // Drives one item and holds it until the handshake edge. valid stays high
   // on return so back-to-back items never drop it for a cycle.
   task automatic send_item(table_req_t it);
      int g;
      g = pick_gap(send_quick);
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= it.mode;
      req_if.load_index <= it.load_index;
      req_if.raw_key    <= it.raw_key;
      req_if.raw_move   <= it.raw_move;
      req_if.raw_weight <= it.raw_weight;
      req_if.raw_learn  <= it.raw_learn;
      req_if.probe_key  <= it.probe_key;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_item(it);
   endtask

   // load with chosen numeric values; the raw words carry them big-endian
   task automatic load_entry_raw(bit [13:0] index, bit [63:0] key, bit [15:0] move,
                                 bit [15:0] weight, bit [31:0] learn);
      table_req_t it;
      it.mode       = MODE_LOAD;
      it.load_index = index;
      it.raw_key    = swap_bytes64(key);
      it.raw_move   = swap_bytes16(move);
      it.raw_weight = swap_bytes16(weight);
      it.raw_learn  = swap_bytes32(learn);
      it.probe_key  = rand64();   // don't-care on a load
      send_item(it);
   endtask

   task automatic load_entry(bit [13:0] index, bit [63:0] key);
      load_entry_raw(index, key, $urandom, $urandom, $urandom);
   endtask

   task automatic send_probe(bit [63:0] key);
      table_req_t it;
      it.mode       = MODE_PROBE;
      it.load_index = $urandom;   // unused fields carry noise
      it.raw_key    = rand64();
      it.raw_move   = $urandom;
      it.raw_weight = $urandom;
      it.raw_learn  = $urandom;
      it.probe_key  = key;
      send_item(it);
   endtask

   // probe for a key that sits in the searched range
   task automatic probe_stored(int n_eff);
      if (n_eff == 0)
         send_probe(rand64());
      else
         send_probe(key_mem[$urandom_range(0, n_eff - 1)]);
   endtask

   // Writes entries 0..n-1 with ascending keys. Steps are random: zero gives
   // duplicate runs, a wrap clamps to all ones so the top key shows up too.
   task automatic fill_sorted(int n, bit [63:0] start, int shift);
      bit [63:0] k, step, nxt;
      int        r;
      k = start;
      for (int i = 0; i < n; i++) begin
         load_entry(i[13:0], k);
         r = $urandom_range(0, 99);
         if (r < 20)
            step = '0;
         else if (r < 30)
            step = 64'd1;
         else
            step = rand64() >> shift;
         nxt = k + step;
         if (nxt < k)
            nxt = '1;
         k = nxt;
      end
   endtask

   // Sender pause: drop valid, let every expected result drain, then give
   // queued loads time to land in the table.
   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // entry_count only changes while the block is idle
   task automatic write_entry_count(bit [skt_pkg::COUNT_W-1:0] value);
      wait_for_idle();
      csr_if.valid       <= 1'b1;
      csr_if.entry_count <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      search_count = value;
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random back-pressure and the result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : recv_drive
      int g;
      if (recv_stall_left > 0) begin
         recv_ready      <= 1'b0;
         recv_stall_left <= recv_stall_left - 1;
      end else if (recv_no_stall) begin
         recv_ready <= 1'b1;
      end else begin
         g = pick_gap(1'b0);
         if (g == 0) begin
            recv_ready <= 1'b1;
         end else begin
            recv_ready      <= 1'b0;
            recv_stall_left <= g - 1;
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      match_t want;
      if (!reset && rsp_if.valid === 1'b1 && recv_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual found=%0d index=%0d last=%0d",
                     $time, rsp_if.found, rsp_if.entry_index, rsp_if.last);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("found",          want.found,          rsp_if.found);
            check_field("entry_index",    want.entry_index,    rsp_if.entry_index);
            check_field("move_word",      want.move_word,      rsp_if.move_word);
            check_field("weight_word",    want.weight_word,    rsp_if.weight_word);
            check_field("learn_word",     want.learn_word,     rsp_if.learn_word);
            check_field("last",           want.last,           rsp_if.last);
            check_field("more_remaining", want.more_remaining, rsp_if.more_remaining);
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // entry_count is 0 out of reset: every probe misses and reads nothing
   task automatic test_reset_state();
      send_probe('0);
      send_probe('1);
      send_probe(rand64());
   endtask

   // small table with key and payload extremes, duplicate pairs at both ends
   task automatic test_directed();
      load_entry_raw(14'd0, 64'd0, 16'h0000, 16'hFFFF, 32'h0000_0000);
      load_entry_raw(14'd1, 64'd0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
      load_entry_raw(14'd2, 64'd5, 16'h00FF, 16'hFF00, 32'h0123_4567);
      load_entry_raw(14'd3, 64'h0123_4567_89AB_CDEF, 16'h1234, 16'h5678, 32'h89AB_CDEF);
      load_entry_raw(14'd4, '1, 16'hA55A, 16'h5AA5, 32'hF0F0_0F0F);
      load_entry_raw(14'd5, '1, 16'h8001, 16'h7FFE, 32'h8000_0001);
      write_entry_count(15'd6);
      send_probe(64'd0);                      // run of two at the bottom
      send_probe('1);                         // run of two at the top
      send_probe(64'd5);
      send_probe(64'd4);                      // miss between entries
      send_probe(64'd6);
      send_probe(64'h0123_4567_89AB_CDEE);
      send_probe(64'h0123_4567_89AB_CDF0);
      send_probe(64'h8000_0000_0000_0000);
      // duplicate just past the searched range must not be reported
      write_entry_count(15'd1);
      send_probe(64'd0);
      write_entry_count(15'd0);
      send_probe(64'd0);
   endtask

   // runs longer than, equal to and cut by the range against the result limit
   task automatic test_truncation();
      bit [63:0] long_key, exact_key;
      long_key  = {2'b10, rand64() >> 2};
      exact_key = long_key + 64'd1 + $urandom;
      for (int i = 0; i < 10; i++)
         load_entry(i[13:0], 64'(i));
      for (int i = 10; i < 80; i++)           // 70 copies
         load_entry(i[13:0], long_key);
      for (int i = 80; i < 144; i++)          // exactly MAX_MATCHES copies
         load_entry(i[13:0], exact_key);
      for (int i = 144; i < 150; i++)
         load_entry(i[13:0], exact_key + 64'd1 + 64'(i));
      write_entry_count(15'd150);
      send_probe(long_key);                   // cut off, more_remaining set
      send_probe(exact_key);                  // full limit, nothing dropped
      send_probe(long_key + 64'd1);
      write_entry_count(15'd75);
      send_probe(long_key);                   // 65 in range: one dropped
      write_entry_count(15'd74);
      send_probe(long_key);                   // 64 in range: none dropped
      write_entry_count(15'd11);
      send_probe(long_key);
   endtask

   // whole table: deepest search, count at the table size and beyond it
   task automatic test_full_table();
      fill_sorted(TABLE_DEPTH, '0, 13);
      write_entry_count(15'(TABLE_DEPTH));
      send_probe(key_mem[0]);
      send_probe(key_mem[TABLE_DEPTH-1]);
      for (int i = 0; i < 16; i++)
         probe_stored(TABLE_DEPTH);
      for (int i = 0; i < 6; i++)
         send_probe(rand64());
      write_entry_count(COUNT_ALL_ONES);      // saturates to the table size
      send_probe(key_mem[TABLE_DEPTH-1]);
      for (int i = 0; i < 6; i++)
         probe_stored(TABLE_DEPTH);
      write_entry_count(15'(TABLE_DEPTH + 1));
      for (int i = 0; i < 4; i++)
         probe_stored(TABLE_DEPTH);
   endtask

   // unsorted contents: the search still takes fixed steps
   task automatic test_unsorted();
      int n;
      n = $urandom_range(8, 32);
      for (int i = 0; i < n; i++)
         load_entry(i[13:0], ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 3))
                                                         : rand64());
      write_entry_count(15'(n));
      for (int i = 0; i < 12; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_probe(64'($urandom_range(0, 3)));
         else
            probe_stored(n);
      end
   endtask

   // Phases: build a fresh sorted prefix, then mostly probes for stored keys,
   // some near misses, payload rewrites that keep order, and random loads.
   task automatic test_random();
      int n, n_eff, r, pause_at, idx;
      for (int p = 0; p < 6; p++) begin
         send_quick    = ($urandom_range(0, 3) == 0);
         recv_no_stall = ($urandom_range(0, 3) == 0);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         fill_sorted(n, rand64() >> $urandom_range(0, 63), $urandom_range(2, 60));
         // entries above n are still loaded from earlier tests
         write_entry_count((p == 3) ? 15'(TABLE_DEPTH) : 15'(n));
         n_eff    = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
         pause_at = $urandom_range(5, 20);
         for (int j = 0; j < 25; j++) begin
            if (j == pause_at)
               wait_for_idle();
            r   = $urandom_range(0, 99);
            idx = $urandom_range(0, n_eff - 1);
            if (r < 65)
               probe_stored(n_eff);
            else if (r < 72)
               send_probe(key_mem[idx] + 64'd1);
            else if (r < 78)
               send_probe(key_mem[idx] - 64'd1);
            else if (r < 82)
               send_probe(rand64());
            else if (r < 94)
               load_entry(idx[13:0], key_mem[idx]);
            else
               load_entry($urandom, rand64());
         end
         send_quick    = 1'b0;
         recv_no_stall = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_LOAD;
      req_if.load_index  <= '0;
      req_if.raw_key     <= '0;
      req_if.raw_move    <= '0;
      req_if.raw_weight  <= '0;
      req_if.raw_learn   <= '0;
      req_if.probe_key   <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.entry_count <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed();
      test_truncation();
      test_full_table();
      test_unsorted();
      test_random();

      wait_for_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
